// ----- hdl/dtsp_pkg.sv -----
package dtsp_pkg;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_TARGET_X      = 3'd0;
    localparam logic [2:0] REG_TARGET_Y      = 3'd1;
    localparam logic [2:0] REG_START_SPEED   = 3'd2;
    localparam logic [2:0] REG_FINAL_SPEED   = 3'd3;
    localparam logic [2:0] REG_ACCEL_FRACTION = 3'd4;
    localparam logic [2:0] REG_DECEL_FRACTION = 3'd5;
    localparam logic [2:0] REG_SPEED_CEILING = 3'd6;
    localparam logic [2:0] REG_SPEED_FLOOR   = 3'd7;

    localparam logic [31:0] START_SPEED_RST   = 32'd655;
    localparam logic [31:0] SPEED_CEILING_RST = 32'd131072;

    localparam int RAD_W  = 66;   // radicand of the distance root
    localparam int ROOT_W = 33;   // distance, Q17.16
    localparam int REM_W  = 35;   // root remainder, holds 2*root
    localparam int DIV_W  = 50;   // ramp numerator and denominator
    localparam int QUO_W  = 32;   // ramp ratio, Q0.32

    localparam logic [16:0] ONE_Q16       = 17'd65536;
    localparam logic [16:0] TINY_MAX      = 17'd6;
    localparam logic [16:0] LOW_ACCEL_MAX = 17'd3276;

    // floor(L/10) = (L * ceil(2^36/10)) >> 36, exact for L < 2^34
    localparam logic [32:0] TENTH_MUL   = 33'd6871947674;
    localparam int          TENTH_SHIFT = 36;

endpackage

// ----- hdl/dtsp_sqrt.sv -----
module dtsp_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dtsp_pkg::RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [dtsp_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]           out_side
);

    localparam int STEPS = dtsp_pkg::ROOT_W;

    logic                        valid_reg [STEPS];
    logic [dtsp_pkg::RAD_W-1:0]  rad_reg   [STEPS];
    logic [dtsp_pkg::REM_W-1:0]  rem_reg   [STEPS];
    logic [dtsp_pkg::ROOT_W-1:0] root_reg  [STEPS];
    logic [SIDE_W-1:0]           side_reg  [STEPS];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic                        v_prev;
        logic [dtsp_pkg::RAD_W-1:0]  rad_prev;
        logic [dtsp_pkg::REM_W-1:0]  rem_prev;
        logic [dtsp_pkg::ROOT_W-1:0] root_prev;
        logic [SIDE_W-1:0]           side_prev;
        logic [dtsp_pkg::REM_W+1:0]  rem_sh;
        logic [dtsp_pkg::REM_W+1:0]  trial;
        logic [dtsp_pkg::REM_W-1:0]  rem_next;
        logic [dtsp_pkg::ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = in_rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign v_prev    = valid_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev, rad_prev[dtsp_pkg::RAD_W-1-2*k -: 2]};
            trial  = {2'b00, root_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = dtsp_pkg::REM_W'(rem_sh - trial);
                root_next = {root_prev[dtsp_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[dtsp_pkg::REM_W-1:0];
                root_next = {root_prev[dtsp_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_prev;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hdl/dtsp_div.sv -----
module dtsp_div #(
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [dtsp_pkg::DIV_W-1:0]   in_num,
    input  logic [dtsp_pkg::DIV_W-1:0]   in_den,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [dtsp_pkg::QUO_W:0]     out_quo,
    output logic [SIDE_W-1:0]            out_side
);

    localparam int STEPS = dtsp_pkg::QUO_W;

    logic                        valid_reg [STEPS];
    logic                        sat_reg   [STEPS];
    logic [dtsp_pkg::DIV_W-1:0]  rem_reg   [STEPS];
    logic [dtsp_pkg::DIV_W-1:0]  den_reg   [STEPS];
    logic [dtsp_pkg::QUO_W-1:0]  quo_reg   [STEPS];
    logic [SIDE_W-1:0]           side_reg  [STEPS];

    // restoring division, one quotient bit per stage; num >= den saturates to one
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic                        v_prev;
        logic                        sat_prev;
        logic [dtsp_pkg::DIV_W-1:0]  rem_prev;
        logic [dtsp_pkg::DIV_W-1:0]  den_prev;
        logic [dtsp_pkg::QUO_W-1:0]  quo_prev;
        logic [SIDE_W-1:0]           side_prev;
        logic [dtsp_pkg::DIV_W:0]    rem_sh;
        logic [dtsp_pkg::DIV_W-1:0]  rem_next;
        logic [dtsp_pkg::QUO_W-1:0]  quo_next;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign sat_prev  = (in_num >= in_den);
            assign rem_prev  = sat_prev ? '0 : in_num;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign v_prev    = valid_reg[k-1];
            assign sat_prev  = sat_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev, 1'b0};
            if (rem_sh >= {1'b0, den_prev})
            begin
                rem_next = dtsp_pkg::DIV_W'(rem_sh - {1'b0, den_prev});
                quo_next = {quo_prev[dtsp_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[dtsp_pkg::DIV_W-1:0];
                quo_next = {quo_prev[dtsp_pkg::QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[k]  <= sat_prev;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_prev;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_quo   = sat_reg[STEPS-1] ? {1'b1, {dtsp_pkg::QUO_W{1'b0}}}
                                        : {1'b0, quo_reg[STEPS-1]};
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hdl/distance_trapezoid_speed_planner_unit.sv -----
// channel | dir | tdata                      | tuser
// s_*     | in  | [31:0] pos_x, [63:32] pos_y | kind (0 start run, 1 plan)
// m_*     | out | [31:0] speed                | [0] accel_error, [1] ratio_warning,
//         |     |                            | [2] past_end
// apb     | in  | register at paddr = 4*index, write on psel&penable&pwrite
//
// One transaction accepted per cycle unless stalled; one result each, in order.
// Pipeline: 4 front stages, 33 root stages, 3 planning stages,
// 32 ratio divider stages and 2 ramp stages.
// The root and divider pipelines set the depth; run_length updates at the root output.
// A stalled result freezes the whole pipeline; s_tready drops only then.
// Reset clears valid bits, run_length and config but sets start speed and ceiling.
module distance_trapezoid_speed_planner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] pos_x, [63:32] pos_y
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] speed
    output logic [2:0]  m_tuser,   // [0] accel_error, [1] ratio_warning, [2] past_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DSIDE_W = 1 + 32 + 32 + 32 + 3;

    logic en;

    // config
    logic [31:0] target_x_reg, target_y_reg, start_speed_reg, final_speed_reg;
    logic [16:0] accel_fraction_reg, decel_fraction_reg;
    logic [31:0] speed_ceiling_reg, speed_floor_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg       <= '0;
            target_y_reg       <= '0;
            start_speed_reg    <= dtsp_pkg::START_SPEED_RST;
            final_speed_reg    <= '0;
            accel_fraction_reg <= '0;
            decel_fraction_reg <= '0;
            speed_ceiling_reg  <= dtsp_pkg::SPEED_CEILING_RST;
            speed_floor_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                dtsp_pkg::REG_TARGET_X:       target_x_reg       <= pwdata;
                dtsp_pkg::REG_TARGET_Y:       target_y_reg       <= pwdata;
                dtsp_pkg::REG_START_SPEED:    start_speed_reg    <= pwdata;
                dtsp_pkg::REG_FINAL_SPEED:    final_speed_reg    <= pwdata;
                dtsp_pkg::REG_ACCEL_FRACTION: accel_fraction_reg <= pwdata[16:0];
                dtsp_pkg::REG_DECEL_FRACTION: decel_fraction_reg <= pwdata[16:0];
                dtsp_pkg::REG_SPEED_CEILING:  speed_ceiling_reg  <= pwdata;
                dtsp_pkg::REG_SPEED_FLOOR:    speed_floor_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            dtsp_pkg::REG_TARGET_X:       prdata = target_x_reg;
            dtsp_pkg::REG_TARGET_Y:       prdata = target_y_reg;
            dtsp_pkg::REG_START_SPEED:    prdata = start_speed_reg;
            dtsp_pkg::REG_FINAL_SPEED:    prdata = final_speed_reg;
            dtsp_pkg::REG_ACCEL_FRACTION: prdata = {15'd0, accel_fraction_reg};
            dtsp_pkg::REG_DECEL_FRACTION: prdata = {15'd0, decel_fraction_reg};
            dtsp_pkg::REG_SPEED_CEILING:  prdata = speed_ceiling_reg;
            dtsp_pkg::REG_SPEED_FLOOR:    prdata = speed_floor_reg;
            default:                      prdata = '0;
        endcase
    end

    // stage 0: input register
    logic        s0_valid_reg, s0_kind_reg;
    logic [31:0] s0_x_reg, s0_y_reg;
    // stage 1: axis distances
    logic        s1_valid_reg, s1_kind_reg;
    logic [31:0] s1_ax_reg, s1_ay_reg;
    logic [32:0] ax_wide, ay_wide;
    // stage 2: squares
    logic        s2_valid_reg, s2_kind_reg;
    logic [63:0] s2_sx_reg, s2_sy_reg;
    // stage 3: sum
    logic        s3_valid_reg, s3_kind_reg;
    logic [64:0] s3_sum_reg;

    assign s_tready = en;

    always_comb
    begin
        ax_wide = {target_x_reg[31], target_x_reg} - {s0_x_reg[31], s0_x_reg};
        ay_wide = {target_y_reg[31], target_y_reg} - {s0_y_reg[31], s0_y_reg};
        if (ax_wide[32])
        begin
            ax_wide = -ax_wide;
        end
        if (ay_wide[32])
        begin
            ay_wide = -ay_wide;
        end
    end

    // sqrt out
    logic                        r_valid;
    logic [dtsp_pkg::ROOT_W-1:0] r_root;
    logic                        r_kind;

    // stage A: run length, travelled distance
    logic        a_valid_reg, a_kind_reg;
    logic [32:0] a_l_reg, a_trav_reg;
    logic [32:0] run_length_reg;
    logic [32:0] l_sel, trav_next;

    // stage B: products, flags
    logic        b_valid_reg, b_kind_reg;
    logic [32:0] b_l_reg, b_trav_reg;
    logic [16:0] b_acc_reg, b_dec_reg;
    logic [49:0] b_acc_area_reg, b_cruise_end_reg, b_dec_area_reg;
    logic [65:0] b_tenth_reg;
    logic        b_accel_err_reg, b_ratio_warn_reg, b_past_reg;
    logic [16:0] acc_c, dec_c;

    // stage C: segment select
    logic        c_valid_reg;
    logic [49:0] c_num_reg, c_den_reg;
    logic [DSIDE_W-1:0] c_side_reg;
    logic [33:0] cruise_wide;
    logic [31:0] cruise;
    logic [48:0] t16, rem16;
    logic        ramp;
    logic [31:0] direct_speed, ramp_from;
    logic [49:0] num_next, den_next;
    logic [2:0]  flags_next;

    // divider out
    logic                    q_valid;
    logic [dtsp_pkg::QUO_W:0] q_quo;
    logic [DSIDE_W-1:0]      q_side;

    // stage D: ramp product
    logic        d_valid_reg, d_up_reg, d_ramp_reg;
    logic [64:0] d_prod_reg;
    logic [31:0] d_from_reg, d_direct_reg;
    logic [2:0]  d_flags_reg;
    logic        q_ramp, q_up;
    logic [31:0] q_direct, q_from, q_to, q_mag;
    logic [2:0]  q_flags;

    // stage E: output register
    logic        e_valid_reg;
    logic [31:0] e_speed_reg;
    logic [2:0]  e_flags_reg;
    logic [32:0] delta;

    assign en = !e_valid_reg || m_tready;

    always_comb
    begin
        l_sel = r_kind ? run_length_reg : r_root;
        if (l_sel >= r_root)
        begin
            trav_next = l_sel - r_root;
        end
        else
        begin
            trav_next = r_root - l_sel;
        end
        acc_c = (accel_fraction_reg > dtsp_pkg::ONE_Q16) ? dtsp_pkg::ONE_Q16
                                                         : accel_fraction_reg;
        dec_c = (decel_fraction_reg > dtsp_pkg::ONE_Q16) ? dtsp_pkg::ONE_Q16
                                                         : decel_fraction_reg;
    end

    always_comb
    begin
        cruise_wide = {1'b0, b_l_reg} +
                      34'(b_tenth_reg[65:dtsp_pkg::TENTH_SHIFT]);
        if (cruise_wide > {2'b00, speed_ceiling_reg})
        begin
            cruise = speed_ceiling_reg;
        end
        else
        begin
            cruise = cruise_wide[31:0];
        end
        if (cruise < speed_floor_reg)
        begin
            cruise = speed_floor_reg;
        end
        if (b_acc_reg <= dtsp_pkg::TINY_MAX)
        begin
            cruise = start_speed_reg;
        end
        else if (b_dec_reg <= dtsp_pkg::TINY_MAX)
        begin
            cruise = final_speed_reg;
        end

        t16   = {b_trav_reg, 16'd0};
        rem16 = {b_l_reg - b_trav_reg, 16'd0};

        ramp         = 1'b0;
        direct_speed = '0;
        ramp_from    = start_speed_reg;
        num_next     = {1'b0, t16};
        den_next     = b_acc_area_reg;
        if (b_accel_err_reg)
        begin
            direct_speed = '0;
        end
        else if ({1'b0, t16} <= b_acc_area_reg && b_acc_reg > dtsp_pkg::TINY_MAX)
        begin
            if (b_acc_area_reg == '0)
            begin
                direct_speed = final_speed_reg;
            end
            else
            begin
                ramp = 1'b1;
            end
        end
        else if ({1'b0, t16} <= b_cruise_end_reg)
        begin
            direct_speed = cruise;
        end
        else if (!b_past_reg)
        begin
            ramp_from = final_speed_reg;
            num_next  = {1'b0, rem16};
            den_next  = b_dec_area_reg;
            if (b_dec_area_reg == '0)
            begin
                direct_speed = final_speed_reg;
            end
            else
            begin
                ramp = 1'b1;
            end
        end

        flags_next = {b_past_reg, b_ratio_warn_reg, b_accel_err_reg};
        // start items report all zero
        if (!b_kind_reg)
        begin
            ramp         = 1'b0;
            direct_speed = '0;
            flags_next   = '0;
        end
    end

    always_comb
    begin
        {q_ramp, q_direct, q_from, q_to, q_flags} = q_side;
        q_up  = (q_to >= q_from);
        q_mag = q_up ? (q_to - q_from) : (q_from - q_to);
        delta = d_prod_reg[64:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            run_length_reg <= '0;
        end
        else if (en)
        begin
            s0_valid_reg <= s_tvalid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            a_valid_reg  <= r_valid;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= q_valid;
            e_valid_reg  <= d_valid_reg;
            if (r_valid && !r_kind)
            begin
                run_length_reg <= r_root;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_kind_reg <= s_tuser;
            s0_x_reg    <= s_tdata[31:0];
            s0_y_reg    <= s_tdata[63:32];

            s1_kind_reg <= s0_kind_reg;
            s1_ax_reg   <= ax_wide[31:0];
            s1_ay_reg   <= ay_wide[31:0];

            s2_kind_reg <= s1_kind_reg;
            s2_sx_reg   <= s1_ax_reg * s1_ax_reg;
            s2_sy_reg   <= s1_ay_reg * s1_ay_reg;

            s3_kind_reg <= s2_kind_reg;
            s3_sum_reg  <= {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};

            a_kind_reg  <= r_kind;
            a_l_reg     <= l_sel;
            a_trav_reg  <= trav_next;

            b_kind_reg       <= a_kind_reg;
            b_l_reg          <= a_l_reg;
            b_trav_reg       <= a_trav_reg;
            b_acc_reg        <= acc_c;
            b_dec_reg        <= dec_c;
            b_acc_area_reg   <= a_l_reg * acc_c;
            b_cruise_end_reg <= a_l_reg * (dtsp_pkg::ONE_Q16 - dec_c);
            b_dec_area_reg   <= a_l_reg * dec_c;
            b_tenth_reg      <= a_l_reg * dtsp_pkg::TENTH_MUL;
            b_accel_err_reg  <= (final_speed_reg > start_speed_reg) &&
                                (acc_c <= dtsp_pkg::LOW_ACCEL_MAX);
            b_ratio_warn_reg <= ({1'b0, acc_c} + {1'b0, dec_c}) > {1'b0, dtsp_pkg::ONE_Q16};
            b_past_reg       <= a_trav_reg > a_l_reg;

            c_num_reg  <= num_next;
            c_den_reg  <= den_next;
            c_side_reg <= {ramp, direct_speed, ramp_from, cruise, flags_next};

            d_up_reg     <= q_up;
            d_ramp_reg   <= q_ramp;
            d_prod_reg   <= q_mag * q_quo;
            d_from_reg   <= q_from;
            d_direct_reg <= q_direct;
            d_flags_reg  <= q_flags;

            e_flags_reg <= d_flags_reg;
            if (!d_ramp_reg)
            begin
                e_speed_reg <= d_direct_reg;
            end
            else if (d_up_reg)
            begin
                e_speed_reg <= d_from_reg + delta[31:0];
            end
            else
            begin
                e_speed_reg <= d_from_reg - delta[31:0];
            end
        end
    end

    dtsp_sqrt #(
        .SIDE_W (1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_rad    ({1'b0, s3_sum_reg}),
        .in_side   (s3_kind_reg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_kind)
    );

    dtsp_div #(
        .SIDE_W (DSIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_num    (c_num_reg),
        .in_den    (c_den_reg),
        .in_side   (c_side_reg),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_side  (q_side)
    );

    assign m_tvalid = e_valid_reg;
    assign m_tdata  = e_speed_reg;
    assign m_tuser  = e_flags_reg;

endmodule

// ----- hdl/dtsp_checker.sv -----
module dtsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[2]) |-> m_tdata == 32'd0)
        else $error("nonzero speed with accel error or past end");

endmodule

bind distance_trapezoid_speed_planner_unit dtsp_checker u_dtsp_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PLAN  = 1'b1;
    localparam int   DRAIN_CYCLES = 100;
    localparam int   HOLD_CYCLES  = 400;
    localparam longint CYCLE_LIMIT = 600000;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

    typedef struct packed {
        logic [31:0] speed;
        logic        past_end;
        logic        ratio_warning;
        logic        accel_error;
    } plan_t;

    typedef struct {
        row_op_t     op;
        logic [2:0]  sel;      // kind for items, register index for writes
        logic [31:0] a;
        logic [31:0] b;
        bit          chk;
        plan_t       res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] pos_x, [63:32] pos_y
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] speed
    logic [2:0]  m_tuser;   // [0] accel_error, [1] ratio_warning, [2] past_end
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    distance_trapezoid_speed_planner_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // planner copy of the block's registers and state
    logic [31:0] tgt_x, tgt_y, v_start, v_final, v_ceil, v_floor;
    logic [16:0] f_acc, f_dec;
    logic [32:0] run_len;

    plan_t  plan_q[$];
    row_t   rows[$];
    int     errors;
    longint cycles;
    bit     offering;
    bit     no_gap;
    bit     hold_go;
    int     burst_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [32:0] dist_to(logic [31:0] px, logic [31:0] py);
        logic signed [32:0] dx, dy;
        logic [32:0] ax, ay;
        logic [65:0] sq;
        logic [67:0] rem, trial;
        logic [33:0] root;
        dx = $signed({tgt_x[31], tgt_x}) - $signed({px[31], px});
        dy = $signed({tgt_y[31], tgt_y}) - $signed({py[31], py});
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = (rem << 2) | 68'(sq[2*i +: 2]);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end
            else
                root = root << 1;
        end
        return root[32:0];
    endfunction

    // Q0.32 ratio, saturates at one
    function automatic logic [32:0] ratio32(logic [63:0] num, logic [63:0] den);
        logic [31:0] q;
        if (num >= den)
            return 33'h1_0000_0000;
        q = '0;
        for (int i = 0; i < 32; i++)
        begin
            num = num << 1;
            q = q << 1;
            if (num >= den)
            begin
                num = num - den;
                q[0] = 1'b1;
            end
        end
        return {1'b0, q};
    endfunction

    function automatic logic [63:0] ramp_to(logic [63:0] from, logic [63:0] to,
                                            logic [32:0] f);
        logic [127:0] p;
        if (to >= from)
        begin
            p = 128'(to - from) * 128'(f);
            return from + p[95:32];
        end
        p = 128'(from - to) * 128'(f);
        return from - p[95:32];
    endfunction

    function automatic plan_t plan_speed(logic kind, logic [31:0] px, logic [31:0] py);
        plan_t r;
        logic [63:0] len, acc, dec, togo, trav, cruise, t16, acc_area, cruise_end, spd;
        r = '0;
        if (kind == KIND_START)
        begin
            run_len = dist_to(px, py);
            return r;
        end
        len = 64'(run_len);
        acc = f_acc > dtsp_pkg::ONE_Q16 ? 64'(dtsp_pkg::ONE_Q16) : 64'(f_acc);
        dec = f_dec > dtsp_pkg::ONE_Q16 ? 64'(dtsp_pkg::ONE_Q16) : 64'(f_dec);
        togo = 64'(dist_to(px, py));
        trav = len >= togo ? len - togo : togo - len;
        r.accel_error = (v_final > v_start) && (acc <= 64'(dtsp_pkg::LOW_ACCEL_MAX));
        r.ratio_warning = (acc + dec) > 64'(dtsp_pkg::ONE_Q16);
        r.past_end = trav > len;
        cruise = len + len / 10;
        if (cruise > 64'(v_ceil))
            cruise = 64'(v_ceil);
        if (cruise < 64'(v_floor))
            cruise = 64'(v_floor);
        if (acc <= 64'(dtsp_pkg::TINY_MAX))
            cruise = 64'(v_start);
        else if (dec <= 64'(dtsp_pkg::TINY_MAX))
            cruise = 64'(v_final);
        t16 = trav << 16;
        acc_area = len * acc;
        cruise_end = len * (64'(dtsp_pkg::ONE_Q16) - dec);
        if (r.accel_error)
            spd = 0;
        else if (t16 <= acc_area && acc > 64'(dtsp_pkg::TINY_MAX))
            spd = acc_area == 0 ? 64'(v_final)
                                : ramp_to(64'(v_start), cruise, ratio32(t16, acc_area));
        else if (t16 <= cruise_end)
            spd = cruise;
        else if (!r.past_end)
            spd = (len * dec) == 0 ? 64'(v_final)
                : ramp_to(64'(v_final), cruise, ratio32((len - trav) << 16, len * dec));
        else
            spd = 0;
        r.speed = spd[31:0];
        return r;
    endfunction

    // wait for every result, then let the pipeline settle
    task automatic go_idle();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (plan_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dtsp_pkg::REG_TARGET_X:       tgt_x = val;
            dtsp_pkg::REG_TARGET_Y:       tgt_y = val;
            dtsp_pkg::REG_START_SPEED:    v_start = val;
            dtsp_pkg::REG_FINAL_SPEED:    v_final = val;
            dtsp_pkg::REG_ACCEL_FRACTION: f_acc = val[16:0];
            dtsp_pkg::REG_DECEL_FRACTION: f_dec = val[16:0];
            dtsp_pkg::REG_SPEED_CEILING:  v_ceil = val;
            default:                      v_floor = val;
        endcase
        @(posedge clk);
    endtask

    task automatic send(logic kind, logic [31:0] px, logic [31:0] py, bit chk, plan_t res);
        int gap;
        plan_t p;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {py, px};
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        p = plan_speed(kind, px, py);
        plan_q.push_back(chk ? res : p);
        if (no_gap)
            return;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h30000);
        endcase
    endfunction

    function automatic logic [31:0] pick_frac();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'(dtsp_pkg::TINY_MAX);
            2: return 32'(dtsp_pkg::TINY_MAX) + 1;
            3: return 32'(dtsp_pkg::LOW_ACCEL_MAX);
            4: return 32'(dtsp_pkg::LOW_ACCEL_MAX) + 1;
            5: return 32'(dtsp_pkg::ONE_Q16);
            6: return $urandom;
            default: return $urandom_range(0, 32'h8000);
        endcase
    endfunction

    function automatic logic [31:0] pick_pos();
        if ($urandom_range(0, 9) < 7)
            return 32'($signed($urandom_range(0, 32'h100000)) - 32'sh80000);
        return $urandom;
    endfunction

    function automatic plan_t res_of(logic [31:0] spd, logic [2:0] flags);
        return {spd, flags};
    endfunction

    function automatic void add_item(logic kind, logic [31:0] x, logic [31:0] y,
                                     bit chk, plan_t res);
        rows.push_back('{ROW_ITEM, {2'b00, kind}, x, y, chk, res});
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
        rows.push_back('{ROW_CFG, idx, val, 32'd0, 1'b0, plan_t'(0)});
    endfunction

    // receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        int mode, left, held;
        mode = 0;
        left = 0;
        held = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                m_tready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES)
                begin
                    hold_go = 1'b0;
                    held = 0;
                end
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        plan_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (plan_q.size() == 0)
            begin
                $error("result transaction with nothing expected: speed %0d", m_tdata);
                errors++;
            end
            else
            begin
                e = plan_q.pop_front();
                if (m_tdata !== e.speed)
                begin
                    $error("speed expected %0d actual %0d", e.speed, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== e.accel_error)
                begin
                    $error("accel_error expected %0d actual %0d", e.accel_error, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.ratio_warning)
                begin
                    $error("ratio_warning expected %0d actual %0d",
                           e.ratio_warning, m_tuser[1]);
                    errors++;
                end
                if (m_tuser[2] !== e.past_end)
                begin
                    $error("past_end expected %0d actual %0d", e.past_end, m_tuser[2]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n_plan, k;
        longint sx, sy, tx, ty, px, py;
        row_t r;
        errors = 0;
        cycles = 0;
        offering = 1'b0;
        no_gap = 1'b0;
        hold_go = 1'b0;
        burst_left = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tgt_x = 0;
        tgt_y = 0;
        v_start = dtsp_pkg::START_SPEED_RST;
        v_final = 0;
        f_acc = 0;
        f_dec = 0;
        v_ceil = dtsp_pkg::SPEED_CEILING_RST;
        v_floor = 0;
        run_len = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: cruise is the start speed; no run yet, so off target is past the end
        add_item(KIND_PLAN, 32'd0, 32'd0, 1, res_of(dtsp_pkg::START_SPEED_RST, 3'b000));
        add_item(KIND_PLAN, 32'h10000, 32'd0, 1, res_of(32'd0, 3'b100));
        add_item(KIND_START, 32'h8000_0000, 32'h8000_0000, 1, res_of(32'd0, 3'b000));
        add_item(KIND_PLAN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, plan_t'(0));
        add_item(KIND_START, 32'h7FFF_FFFF, 32'h8000_0000, 1, res_of(32'd0, 3'b000));
        add_item(KIND_PLAN, 32'd0, 32'd0, 0, plan_t'(0));
        // acceleration too low
        add_cfg(dtsp_pkg::REG_FINAL_SPEED, 32'h10000);
        add_cfg(dtsp_pkg::REG_ACCEL_FRACTION, 32'(dtsp_pkg::LOW_ACCEL_MAX));
        add_item(KIND_START, 32'h40000, 32'd0, 1, res_of(32'd0, 3'b000));
        add_item(KIND_PLAN, 32'h20000, 32'd0, 1, res_of(32'd0, 3'b001));
        // fractions above one, ratio sum above one
        add_cfg(dtsp_pkg::REG_ACCEL_FRACTION, 32'(dtsp_pkg::LOW_ACCEL_MAX) + 1);
        add_cfg(dtsp_pkg::REG_DECEL_FRACTION, 32'h1FFFF);
        add_item(KIND_PLAN, 32'h30000, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'h10000, 32'd0, 0, plan_t'(0));
        add_cfg(dtsp_pkg::REG_ACCEL_FRACTION, 32'hFFFF_FFFF);
        add_cfg(dtsp_pkg::REG_DECEL_FRACTION, 32'h8000);
        add_item(KIND_PLAN, 32'h20000, 32'd0, 0, plan_t'(0));
        // regular trapezoid along the run, behind the start and beyond the target
        add_cfg(dtsp_pkg::REG_ACCEL_FRACTION, 32'h4000);
        add_cfg(dtsp_pkg::REG_DECEL_FRACTION, 32'h4000);
        add_cfg(dtsp_pkg::REG_SPEED_CEILING, 32'hFFFF_FFFF);
        add_item(KIND_PLAN, 32'h3C000, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'h20000, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'h04000, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'd0, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'hFFFF_0000, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'h50000, 32'd0, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'hC0000, 32'd0, 1, res_of(32'd0, 3'b100));
        // zero-length run: ramp has no length, speed is the final speed
        add_item(KIND_START, 32'd0, 32'd0, 1, res_of(32'd0, 3'b000));
        add_item(KIND_PLAN, 32'd0, 32'd0, 1, res_of(32'h10000, 3'b000));
        // clamps crossed: floor wins
        add_cfg(dtsp_pkg::REG_SPEED_FLOOR, 32'hFFFF_FFFF);
        add_cfg(dtsp_pkg::REG_SPEED_CEILING, 32'd0);
        add_item(KIND_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, plan_t'(0));
        add_item(KIND_PLAN, 32'h4000_0000, 32'h4000_0000, 0, plan_t'(0));

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.op == ROW_CFG)
            begin
                go_idle();
                cfg_write(r.sel, r.a);
            end
            else
                send(r.sel[0], r.a, r.b, r.chk, r.res);
        end

        for (int phase = 0; phase < 14; phase++)
        begin
            go_idle();
            cfg_write(dtsp_pkg::REG_TARGET_X, pick_pos());
            cfg_write(dtsp_pkg::REG_TARGET_Y, pick_pos());
            cfg_write(dtsp_pkg::REG_START_SPEED, pick_speed());
            cfg_write(dtsp_pkg::REG_FINAL_SPEED, pick_speed());
            cfg_write(dtsp_pkg::REG_ACCEL_FRACTION, pick_frac());
            cfg_write(dtsp_pkg::REG_DECEL_FRACTION, pick_frac());
            cfg_write(dtsp_pkg::REG_SPEED_CEILING, pick_speed());
            cfg_write(dtsp_pkg::REG_SPEED_FLOOR,
                      ($urandom_range(0, 2) == 0) ? pick_speed() : 32'd0);
            @(posedge clk);
            if (phase == 3)
            begin
                // long receiver hold-off while items keep coming
                hold_go = 1'b1;
                no_gap = 1'b1;
                for (int j = 0; j < 150; j++)
                    send(KIND_PLAN, pick_pos(), pick_pos(), 0, plan_t'(0));
                no_gap = 1'b0;
            end
            tx = longint'($signed(tgt_x));
            ty = longint'($signed(tgt_y));
            for (int j = 0; j < 120; )
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    send(1'($urandom_range(0, 1)), $urandom, $urandom, 0, plan_t'(0));
                    j++;
                end
                else
                begin
                    if ($urandom_range(0, 9) < 9)
                    begin
                        sx = tx + longint'($urandom_range(0, 32'h100000)) - 64'sh80000;
                        sy = ty + longint'($urandom_range(0, 32'h100000)) - 64'sh80000;
                    end
                    else
                    begin
                        sx = longint'($signed($urandom));
                        sy = longint'($signed($urandom));
                    end
                    send(KIND_START, 32'(sx), 32'(sy), 0, plan_t'(0));
                    j++;
                    n_plan = $urandom_range(1, 12);
                    for (int m = 0; m < n_plan; m++)
                    begin
                        k = $urandom_range(0, 20);
                        px = sx + ((tx - sx) * k) / 16 + longint'($urandom_range(0, 512)) - 256;
                        py = sy + ((ty - sy) * k) / 16 + longint'($urandom_range(0, 512)) - 256;
                        send(KIND_PLAN, 32'(px), 32'(py), 0, plan_t'(0));
                        j++;
                    end
                end
                if (phase == 6 && j >= 60 && j < 74)
                begin
                    // sender pauses until the pipeline is empty
                    go_idle();
                    j = 74;
                end
            end
        end

        go_idle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dtsp_pkg.sv
hdl/dtsp_sqrt.sv
hdl/dtsp_div.sv
hdl/distance_trapezoid_speed_planner_unit.sv
hdl/dtsp_checker.sv
verif/testbench.sv
